>>> sv/dws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dws_pkg;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 16;

    // width of a word length or byte count, 0..MAX_WORD_LEN
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    // width of the stored word count, 0..MAX_WORDS
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    // width of a cell index, 0..MAX_WORDS-1
    localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    // width of a position in the byte and breakable windows
    localparam int POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_TEXT   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef logic [MAX_WORD_LEN-1:0][7:0] byte_window_t;

    // broadcast from the control logic to every cell
    typedef struct packed {
        logic             shift_en;   // load one word byte into the cell being filled
        logic             commit;     // close the word in the cell being filled
        logic [LEN_W-1:0] commit_len;
        logic [7:0]       char_code;
        logic [CNT_W-1:0] word_count; // stored words; also index of the cell being filled
        byte_window_t     text_win;   // text bytes including the current one, 0 newest
        logic [MAX_WORD_LEN-1:0] brk_win; // breakable bits before the current byte
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/dws_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dws_cell
(
    input  wire logic                      clk,
    input  wire logic [dws_pkg::WIDX_W-1:0] cell_idx,
    input  wire dws_pkg::cell_ctl_t        ctl,
    input  wire logic                      hit_in,
    output logic                           hit_out
);

    localparam int LW  = dws_pkg::LEN_W;
    localparam int CW  = dws_pkg::CNT_W;
    localparam int PW  = dws_pkg::POS_W;
    localparam int WL  = dws_pkg::MAX_WORD_LEN;

    // word bytes, index 0 is the last byte of the word
    dws_pkg::byte_window_t word_reg;
    dws_pkg::byte_window_t word_next;
    logic [LW-1:0]         len_reg;
    logic [LW-1:0]         len_next;

    logic          selected;
    logic          active;
    logic [WL-1:0] eq;
    logic [LW-1:0] len_m1;
    logic          match;

    assign selected = (ctl.word_count == CW'(cell_idx));
    assign active   = (CW'(cell_idx) < ctl.word_count);

    always_comb
    begin
        word_next = word_reg;
        len_next  = len_reg;
        if (selected && ctl.shift_en)
        begin
            for (int k = WL - 1; k > 0; k--)
            begin
                word_next[k] = word_reg[k-1];
            end
            word_next[0] = ctl.char_code;
        end
        if (selected && ctl.commit)
        begin
            len_next = ctl.commit_len;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        len_reg  <= len_next;
    end

    // compare only the positions the word covers
    always_comb
    begin
        for (int k = 0; k < WL; k++)
        begin
            eq[k] = (word_reg[k] == ctl.text_win[k]) || (LW'(k) >= len_reg);
        end
    end

    assign len_m1 = len_reg - LW'(1);
    assign match  = active && (&eq) && ctl.brk_win[len_m1[PW-1:0]];

    // pass the hit down the row
    assign hit_out = hit_in | match;

endmodule

`default_nettype wire

>>> sv/dictionary_word_segmentation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata (low bit up)                     | tuser      | tlast
// s_*     | in  | char_code[7:0]                         | mode[1:0]  | last
// m_*     | out | prefix_breakable[0], status[2:1], pad  | -          | string_done
//
// One character in, one result out, one per cycle while the output is taken; a
// result appears the cycle after its character is accepted; in text mode it is
// set by the row of cells that all compare with the text window that cycle.
// Reset empties the dictionary and restarts the text; no clearing pass.
// A result held by a stalled output blocks input only while it is not taken.

module dictionary_word_segmentation_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code[7:0]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    input  wire logic        s_tlast,   // last

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // prefix_breakable[0], status[2:1]
    output logic             m_tlast    // string_done
);

    localparam int LW = dws_pkg::LEN_W;
    localparam int CW = dws_pkg::CNT_W;
    localparam int WL = dws_pkg::MAX_WORD_LEN;
    localparam int MW = dws_pkg::MAX_WORDS;

    logic [1:0] mode;
    logic [7:0] char_code;
    logic       last;
    logic       accept;

    logic [CW-1:0]         word_count_reg, word_count_next;
    logic [LW-1:0]         pend_len_reg, pend_len_next;
    logic                  pend_ovf_reg, pend_ovf_next;
    dws_pkg::byte_window_t text_win_reg, text_win_next, text_win_shift;
    logic [WL-1:0]         brk_win_reg, brk_win_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_brk_reg, out_brk_next;
    logic          out_done_reg, out_done_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          room;
    logic          ovf_now;
    logic [LW-1:0] len_now;
    logic          brk;

    dws_pkg::cell_ctl_t ctl;
    logic [MW:0]        hit;

    assign mode      = s_tuser;
    assign char_code = s_tdata;
    assign last      = s_tlast;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign room    = (pend_len_reg < LW'(WL));
    assign ovf_now = pend_ovf_reg || !room;
    assign len_now = room ? (pend_len_reg + LW'(1)) : pend_len_reg;

    always_comb
    begin
        for (int k = WL - 1; k > 0; k--)
        begin
            text_win_shift[k] = text_win_reg[k-1];
        end
        text_win_shift[0] = char_code;
    end

    always_comb
    begin
        ctl.shift_en   = accept && (mode == dws_pkg::MODE_WORD) && room;
        ctl.commit     = accept && (mode == dws_pkg::MODE_WORD) && last && !ovf_now;
        ctl.commit_len = len_now;
        ctl.char_code  = char_code;
        ctl.word_count = word_count_reg;
        ctl.text_win   = text_win_shift;
        ctl.brk_win    = brk_win_reg;
    end

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < MW; i++)
    begin : g_cell
        dws_cell u_cell
        (
            .clk      (clk),
            .cell_idx (dws_pkg::WIDX_W'(i)),
            .ctl      (ctl),
            .hit_in   (hit[i]),
            .hit_out  (hit[i+1])
        );
    end

    assign brk = hit[MW];

    always_comb
    begin
        word_count_next = word_count_reg;
        pend_len_next   = pend_len_reg;
        pend_ovf_next   = pend_ovf_reg;
        text_win_next   = text_win_reg;
        brk_win_next    = brk_win_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_brk_next    = out_brk_reg;
        out_done_next   = out_done_reg;
        out_status_next = out_status_reg;

        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_brk_next    = 1'b0;
            out_done_next   = 1'b0;
            out_status_next = dws_pkg::STATUS_OK;
            case (mode)
                dws_pkg::MODE_CLEAR:
                begin
                    word_count_next = '0;
                    pend_len_next   = '0;
                    pend_ovf_next   = 1'b0;
                    text_win_next   = '0;
                    brk_win_next    = WL'(1);
                end
                dws_pkg::MODE_WORD:
                begin
                    pend_len_next = len_now;
                    pend_ovf_next = ovf_now;
                    if (last)
                    begin
                        if (ovf_now)
                        begin
                            out_status_next = dws_pkg::STATUS_TOO_LONG;
                        end
                        else if (word_count_reg >= CW'(MW))
                        begin
                            out_status_next = dws_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            word_count_next = word_count_reg + CW'(1);
                        end
                        pend_len_next = '0;
                        pend_ovf_next = 1'b0;
                    end
                end
                dws_pkg::MODE_TEXT:
                begin
                    out_brk_next  = brk;
                    out_done_next = last;
                    if (last)
                    begin
                        text_win_next = '0;
                        brk_win_next  = WL'(1);
                    end
                    else
                    begin
                        text_win_next = text_win_shift;
                        brk_win_next  = {brk_win_reg[WL-2:0], brk};
                    end
                end
                default:
                begin
                    // unused mode: answer zero, hold state
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            pend_len_reg   <= '0;
            pend_ovf_reg   <= 1'b0;
            text_win_reg   <= '0;
            brk_win_reg    <= WL'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            pend_len_reg   <= pend_len_next;
            pend_ovf_reg   <= pend_ovf_next;
            text_win_reg   <= text_win_next;
            brk_win_reg    <= brk_win_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_brk_reg    <= out_brk_next;
        out_done_reg   <= out_done_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_brk_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire
